@@ hw/rtl/next_fit_block_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the next-fit block allocator
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define NFBA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The expression must never be true outside reset.
`define NFBA_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define NFBA_ASSERT(label, clk, rstn, prop, msg)
`define NFBA_ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

@@ hw/rtl/nfba_pkg.sv @@
// ----------------------------------------------------------------------------
// Next-fit block allocator package
// Field widths, item kinds, result status codes and default ring size.
// ----------------------------------------------------------------------------
package nfba_pkg;

    // Default number of blocks the ring can hold.
    localparam int DEF_MAX_BLOCKS = 64;

    // Field widths.
    localparam int SITE_W  = 31;
    localparam int AMT_W   = 31;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int TDATA_W = 64;

    // Item kinds carried on s_tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_ALLOC  = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // Result status carried on m_tuser.
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_EMPTY   = 2'd2
    } status_t;

endpackage

@@ hw/rtl/nfba_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module nfba_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/next_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Next-fit block allocator
// Ring of free blocks in two RAMs (site, free amount) with a search cursor.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata (low bit up)        | tuser       | tlast
//  s_      | input     | block_site, amount, pad   | kind        | -
//  m_      | output    | site, remaining, pad      | status      | last
//
//  Append and clear go straight to the result state after acceptance.
//  Allocate and report first walk the ring from the search cursor;
//  the walk reads one block per cycle from the two RAM read ports.
//  A new item is accepted only when the previous one has loaded its last
//  result into the output register; a stalled result port pauses a report walk.
//  Reset clears the ring, the cursor and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`include "next_fit_block_allocator_defines.svh"

module next_fit_block_allocator #(
    parameter int MAX_BLOCKS = nfba_pkg::DEF_MAX_BLOCKS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input items.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [nfba_pkg::TDATA_W-1:0] s_tdata,  // [30:0] block_site, [61:31] amount
    input  logic [nfba_pkg::KIND_W-1:0]  s_tuser,  // [1:0] kind
    // Result items.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [nfba_pkg::TDATA_W-1:0] m_tdata,  // [30:0] site, [61:31] remaining
    output logic [nfba_pkg::STAT_W-1:0]  m_tuser,  // [1:0] status
    output logic                         m_tlast
);

    import nfba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t              state_reg;
    kind_t               kind_reg;
    logic [AMT_W-1:0]    amt_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    cursor_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    seen_reg;

    // Held report entry, waiting to learn whether it is the final one.
    logic                pend_valid_reg;
    logic [SITE_W-1:0]   pend_site_reg;
    logic [AMT_W-1:0]    pend_free_reg;

    // Final result of the current item.
    status_t             res_status_reg;
    logic [SITE_W-1:0]   res_site_reg;
    logic [AMT_W-1:0]    res_rem_reg;

    // Output register.
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [SITE_W-1:0]   m_site_reg;
    logic [AMT_W-1:0]    m_rem_reg;
    logic                m_last_reg;

    // Input fields.
    kind_t               in_kind;
    logic [SITE_W-1:0]   in_site;
    logic [AMT_W-1:0]    in_amt;
    logic                accept;

    // RAM ports.
    logic                site_we;
    logic                free_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [AMT_W-1:0]    free_wdata;
    logic [IDX_W-1:0]    rd_addr;
    logic [SITE_W-1:0]   site_rd;
    logic [AMT_W-1:0]    free_rd;

    // Walk control.
    logic [IDX_W-1:0]    start_idx;
    logic [IDX_W-1:0]    nxt_idx;
    logic                full;
    logic                last_blk;
    logic                fit;
    logic                hit;
    logic                out_free;
    logic                stall;
    logic                push_pend;
    logic                advance;
    logic                is_alloc;
    logic                load_out;
    logic [AMT_W-1:0]    free_left;

    assign in_kind = kind_t'(s_tuser);
    assign in_site = s_tdata[SITE_W-1:0];
    assign in_amt  = s_tdata[SITE_W+AMT_W-1:SITE_W];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Search start and ring successor.
    assign start_idx = (CNT_W'(cursor_reg) < count_reg) ? cursor_reg : '0;
    assign nxt_idx   = (CNT_W'(idx_reg) == count_reg - CNT_W'(1)) ? '0 : idx_reg + IDX_W'(1);
    assign full      = (count_reg >= CNT_W'(MAX_BLOCKS));
    assign last_blk  = (seen_reg == count_reg);

    // Evaluation of the block whose data sits on the RAM outputs.
    assign is_alloc  = (kind_reg == KIND_ALLOC);
    assign fit       = (free_rd >= amt_reg);
    assign hit       = (free_rd != '0);
    assign free_left = free_rd - amt_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign stall     = (state_reg == S_SCAN) && !is_alloc && hit && pend_valid_reg && !out_free;
    assign push_pend = (state_reg == S_SCAN) && !is_alloc && hit && pend_valid_reg && out_free;
    assign advance   = (state_reg == S_SCAN) && !last_blk && (is_alloc ? !fit : !stall);

    // The output register loads a held report entry or the final result.
    assign load_out  = push_pend || ((state_reg == S_RESULT) && out_free);

    // RAM addressing: new blocks go to the ring's end, grants update in place.
    always_comb begin
        site_we    = accept && (in_kind == KIND_APPEND) && !full;
        free_we    = site_we || ((state_reg == S_SCAN) && is_alloc && fit);
        wr_addr    = (state_reg == S_IDLE) ? count_reg[IDX_W-1:0] : idx_reg;
        free_wdata = (state_reg == S_IDLE) ? in_amt : free_left;
        if (state_reg == S_IDLE) begin
            rd_addr = start_idx;
        end else if (advance) begin
            rd_addr = nxt_idx;
        end else begin
            rd_addr = idx_reg;
        end
    end

    nfba_ram #(
        .WIDTH (SITE_W),
        .DEPTH (MAX_BLOCKS)
    ) u_site_ram (
        .aclk    (aclk),
        .wr_en   (site_we),
        .wr_addr (wr_addr),
        .wr_data (in_site),
        .rd_addr (rd_addr),
        .rd_data (site_rd)
    );

    nfba_ram #(
        .WIDTH (AMT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (free_we),
        .wr_addr (wr_addr),
        .wr_data (free_wdata),
        .rd_addr (rd_addr),
        .rd_data (free_rd)
    );

    // Sequencer, ring state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        kind_reg <= in_kind;
                        amt_reg  <= in_amt;
                        case (in_kind)
                            KIND_APPEND: begin
                                if (full) begin
                                    res_status_reg <= ST_REFUSED;
                                    res_site_reg   <= '0;
                                    res_rem_reg    <= '0;
                                end else begin
                                    res_status_reg <= ST_OK;
                                    res_site_reg   <= in_site;
                                    res_rem_reg    <= in_amt;
                                    count_reg      <= count_reg + CNT_W'(1);
                                end
                                state_reg <= S_RESULT;
                            end
                            KIND_ALLOC, KIND_REPORT: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= (in_kind == KIND_ALLOC) ? ST_REFUSED
                                                                              : ST_EMPTY;
                                    res_site_reg   <= '0;
                                    res_rem_reg    <= '0;
                                    state_reg      <= S_RESULT;
                                end else begin
                                    idx_reg        <= start_idx;
                                    seen_reg       <= CNT_W'(1);
                                    pend_valid_reg <= 1'b0;
                                    state_reg      <= S_SCAN;
                                end
                            end
                            default: begin
                                count_reg      <= '0;
                                cursor_reg     <= '0;
                                res_status_reg <= ST_OK;
                                res_site_reg   <= '0;
                                res_rem_reg    <= '0;
                                state_reg      <= S_RESULT;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    if (is_alloc) begin
                        // Allocate stops at the first block that fits.
                        if (fit) begin
                            cursor_reg     <= idx_reg;
                            res_status_reg <= ST_OK;
                            res_site_reg   <= site_rd;
                            res_rem_reg    <= free_left;
                            state_reg      <= S_RESULT;
                        end else if (last_blk) begin
                            res_status_reg <= ST_REFUSED;
                            res_site_reg   <= '0;
                            res_rem_reg    <= '0;
                            state_reg      <= S_RESULT;
                        end
                    end else if (!stall) begin
                        // Report sends the held entry once a later one appears.
                        if (push_pend) begin
                            m_status_reg <= ST_OK;
                            m_site_reg   <= pend_site_reg;
                            m_rem_reg    <= pend_free_reg;
                            m_last_reg   <= 1'b0;
                        end
                        if (last_blk) begin
                            pend_valid_reg <= 1'b0;
                        end else if (hit) begin
                            pend_valid_reg <= 1'b1;
                        end
                        if (hit) begin
                            pend_site_reg  <= site_rd;
                            pend_free_reg  <= free_rd;
                        end
                        if (last_blk) begin
                            state_reg      <= S_RESULT;
                            if (hit) begin
                                res_status_reg <= ST_OK;
                                res_site_reg   <= site_rd;
                                res_rem_reg    <= free_rd;
                            end else if (pend_valid_reg) begin
                                res_status_reg <= ST_OK;
                                res_site_reg   <= pend_site_reg;
                                res_rem_reg    <= pend_free_reg;
                            end else begin
                                res_status_reg <= ST_EMPTY;
                                res_site_reg   <= '0;
                                res_rem_reg    <= '0;
                            end
                        end
                    end
                    if (advance) begin
                        idx_reg  <= nxt_idx;
                        seen_reg <= seen_reg + CNT_W'(1);
                    end
                end

                S_RESULT: begin
                    // Final result of the item, marked last.
                    if (out_free) begin
                        m_status_reg <= res_status_reg;
                        m_site_reg   <= res_site_reg;
                        m_rem_reg    <= res_rem_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(TDATA_W - SITE_W - AMT_W)'(0), m_rem_reg, m_site_reg};

    // The ring never holds more blocks than it has room for.
    `NFBA_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_BLOCKS), "block count above ring size")
    // The cursor always names a block of a non-empty ring, or is zero.
    `NFBA_ASSERT(a_cursor_in_ring, aclk, aresetn, (count_reg == '0) |-> (cursor_reg == '0), "cursor set on empty ring")
    `NFBA_ASSERT(a_cursor_below, aclk, aresetn, (count_reg != '0) |-> (CNT_W'(cursor_reg) < count_reg), "cursor beyond ring end")
    // No report entry is left held while a new item may enter.
    `NFBA_ASSERT_NEVER(a_pend_idle, aclk, aresetn, s_tready && pend_valid_reg, "held report entry at idle")

endmodule

@@ sim/tb_next_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the next-fit block allocator
// Drives append, allocate, report and clear items through the input stream
// and checks every result against an in-bench next-fit ring predictor. The
// run covers a directed start, a fill past ring capacity under a long result
// stall, and random traffic under changing idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_next_fit_block_allocator;
    import nfba_pkg::*;

    localparam int RING_DEPTH  = DEF_MAX_BLOCKS;
    localparam int TAIL_CYCLES = RING_DEPTH + 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PRINT_CAP   = 100;

    typedef logic [SITE_W-1:0] site_t;
    typedef logic [AMT_W-1:0]  amount_t;

    // One expected result item.
    typedef struct {
        status_t status;
        site_t   site;
        amount_t remaining;
        logic    last;
    } alloc_result_t;

    // Next-fit ring predictor and the queue of results it expects.
    class alloc_scoreboard;
        site_t         block_site [RING_DEPTH];
        amount_t       block_free [RING_DEPTH];
        logic [6:0]    block_count = '0;
        logic [5:0]    cursor = '0;
        alloc_result_t expected_results[$];
        int            errors = 0;

        task report_mismatch(input string msg);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("%t mismatch: %s", $realtime, msg);
            end
        endtask

        function void push_result(status_t st, site_t s, amount_t rem, logic last);
            alloc_result_t r;
            r.status    = st;
            r.site      = s;
            r.remaining = rem;
            r.last      = last;
            expected_results.push_back(r);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Work out the results of one accepted input item.
        function void predict_item(kind_t kind, site_t bsite, amount_t amt);
            int idx;
            int n;
            bit hit;
            idx = (cursor < block_count) ? int'(cursor) : 0;
            n   = 0;
            hit = 1'b0;
            case (kind)
                KIND_APPEND: begin
                    if (block_count >= RING_DEPTH) begin
                        push_result(ST_REFUSED, '0, '0, 1'b1);
                    end else begin
                        block_site[block_count] = bsite;
                        block_free[block_count] = amt;
                        block_count++;
                        push_result(ST_OK, bsite, amt, 1'b1);
                    end
                end
                KIND_ALLOC: begin
                    // Scan once around the ring for the first block that fits.
                    for (int i = 0; i < block_count && !hit; i++) begin
                        if (block_free[idx] >= amt) begin
                            block_free[idx] = block_free[idx] - amt;
                            cursor = idx[5:0];
                            push_result(ST_OK, block_site[idx], block_free[idx], 1'b1);
                            hit = 1'b1;
                        end else begin
                            idx++;
                            if (idx >= block_count) idx = 0;
                        end
                    end
                    if (!hit) push_result(ST_REFUSED, '0, '0, 1'b1);
                end
                KIND_REPORT: begin
                    // List every block with free space, starting at the cursor.
                    for (int i = 0; i < block_count; i++) begin
                        if (block_free[idx] != '0) begin
                            push_result(ST_OK, block_site[idx], block_free[idx], 1'b0);
                            n++;
                        end
                        idx++;
                        if (idx >= block_count) idx = 0;
                    end
                    if (n == 0) begin
                        push_result(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        expected_results[expected_results.size() - 1].last = 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    block_count = '0;
                    cursor      = '0;
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            endcase
        endfunction

        // Compare one result item with the oldest expectation.
        task check_result(input status_t st, input site_t s, input amount_t rem,
                          input logic last);
            alloc_result_t exp_r;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: status %0d site %h",
                                          st, s));
                return;
            end
            exp_r = expected_results.pop_front();
            if (st !== exp_r.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, exp_r.status));
            if (s !== exp_r.site)
                report_mismatch($sformatf("site %h, expected %h", s, exp_r.site));
            if (rem !== exp_r.remaining)
                report_mismatch($sformatf("remaining %h, expected %h", rem, exp_r.remaining));
            if (last !== exp_r.last)
                report_mismatch($sformatf("last %b, expected %b", last, exp_r.last));
        endtask
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]   m_tuser;
    logic                m_tlast;

    alloc_scoreboard sb = new;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int unsigned cycle_count = 0;

    next_fit_block_allocator #(
        .MAX_BLOCKS(RING_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [30:0] block_site, [61:31] amount
        .s_tuser  (s_tuser),   // [1:0] kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [30:0] site, [61:31] remaining
        .m_tuser  (m_tuser),   // [1:0] status
        .m_tlast  (m_tlast)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Timeout on a cycle count.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_next_fit_block_allocator: errors");
        $finish;
    end

    // Result side: a long hold-off when requested, otherwise random stalls.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every result item taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(status_t'(m_tuser), m_tdata[SITE_W-1:0],
                            m_tdata[SITE_W+AMT_W-1:SITE_W], m_tlast);
        end
    end

    function automatic logic [30:0] rand31();
        return 31'($urandom() & 32'h7FFF_FFFF);
    endfunction

    // Offer one item, with random idle cycles ahead of it, and wait for it
    // to be taken. Returns right after the accepting edge.
    task automatic send_item(input kind_t kind, input site_t bsite, input amount_t amt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, amt, bsite};
        s_tuser  <= kind;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.predict_item(kind, bsite, amt);
    endtask

    // Stop offering items until every expected result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Random traffic: mostly appends and allocations, some reports and clears.
    task automatic random_traffic(input int n_items);
        int      pick;
        kind_t   kind;
        amount_t amt;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = KIND_APPEND;
            else if (pick < 76) kind = KIND_ALLOC;
            else if (pick < 94) kind = KIND_REPORT;
            else                kind = KIND_CLEAR;
            pick = $urandom_range(0, 99);
            if (kind == KIND_ALLOC && pick < 15) amt = '0;
            else if (pick < 55)                  amt = AMT_W'($urandom_range(0, 1000));
            else                                 amt = rand31();
            send_item(kind, rand31(), amt);
        end
    endtask

    initial begin
        // Hold reset, then release it.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed start: empty ring, field extremes, zero request, refusals.
        send_idle_pct = 37;
        recv_idle_pct = 77;
        send_item(KIND_REPORT, '0, '0);
        send_item(KIND_ALLOC, '0, 31'd5);
        send_item(KIND_APPEND, '0, '0);
        send_item(KIND_APPEND, '1, '1);
        send_item(KIND_APPEND, 31'h0000_1234, 31'd100);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_ALLOC, '0, '1);
        send_item(KIND_ALLOC, '0, 31'd50);
        send_item(KIND_ALLOC, '0, 31'd60);
        send_item(KIND_REPORT, '1, '1);
        send_item(KIND_APPEND, 31'h5555_5555, 31'h2AAA_AAAA);
        send_item(KIND_ALLOC, '0, 31'd1);
        send_item(KIND_REPORT, '0, '0);
        send_item(KIND_CLEAR, '1, '1);
        send_item(KIND_REPORT, '0, '0);
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_APPEND, 31'd7, '1);
        send_item(KIND_ALLOC, '0, '1);
        send_item(KIND_REPORT, '0, '0);
        send_item(KIND_CLEAR, '0, '0);
        wait_drained();

        // Fill the ring past capacity while the receiver holds off, list the
        // whole ring, then allocate from it and list it again.
        hold_left <= 300;
        for (int i = 0; i <= RING_DEPTH; i++) begin
            send_item(KIND_APPEND, rand31(), AMT_W'($urandom_range(1, 5000)));
        end
        send_item(KIND_REPORT, '0, '0);
        for (int i = 0; i < 6; i++) begin
            send_item(KIND_ALLOC, '0, AMT_W'($urandom_range(0, 6000)));
        end
        send_item(KIND_REPORT, '0, '0);
        wait_drained();
        send_item(KIND_CLEAR, '0, '0);

        // Random traffic under three idle patterns.
        send_idle_pct = 37;
        recv_idle_pct = 77;
        random_traffic(55);
        send_idle_pct = 77;
        recv_idle_pct = 37;
        random_traffic(55);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(47);

        // Let the last results come out, then a short quiet tail.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("tb_next_fit_block_allocator: clean");
        end else begin
            $display("tb_next_fit_block_allocator: errors");
        end
        $finish;
    end

endmodule
